// File: design/glyph_blit_alpha_blend_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the glyph blit alpha blend unit
// Shared concurrent assertion forms, reset-gated, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef GLYPH_BLIT_ALPHA_BLEND_UNIT_MACROS_SVH
`define GLYPH_BLIT_ALPHA_BLEND_UNIT_MACROS_SVH

// Same-cycle implication.
`define GBAB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define GBAB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: design/gbab_pkg.sv
// ----------------------------------------------------------------------------
// gbab_pkg
// Types and fixed constants of the glyph blit alpha blend unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbab_pkg;

  localparam int MAX_TARGET_WIDTH  = 256;
  localparam int MAX_TARGET_HEIGHT = 256;

  // Clamp limits on the 9-bit size registers
  localparam logic [8:0] W_LIMIT = (MAX_TARGET_WIDTH < 511) ? 9'(MAX_TARGET_WIDTH) : 9'd511;
  localparam logic [8:0] H_LIMIT = (MAX_TARGET_HEIGHT < 511) ? 9'(MAX_TARGET_HEIGHT) : 9'd511;

  localparam int IDX_W    = 16;
  localparam int WORD_W   = 32;
  localparam int APB_AW   = 5;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_POS_X    = 3'd0;
  localparam logic [2:0] REG_POS_Y    = 3'd1;
  localparam logic [2:0] REG_TOP_LINE = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_HEIGHT   = 3'd4;
  localparam logic [2:0] REG_MIRROR_X = 3'd5;
  localparam logic [2:0] REG_MIRROR_Y = 3'd6;
  localparam logic [2:0] REG_COLOR    = 3'd7;

  typedef enum logic [1:0] {
    ACT_BLIT  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } gbab_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLACE,
    ST_INDEX,
    ST_READ,
    ST_MULT,
    ST_DONE
  } gbab_state_t;

endpackage

// File: design/gbab_if.sv
// ----------------------------------------------------------------------------
// gbab interfaces
// Valid/ready channels for blit, write and read requests and their results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gbab_req_if import gbab_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [7:0]        glyph_x;
  logic [7:0]        glyph_y;
  logic [7:0]        src_byte0;
  logic [7:0]        src_byte1;
  logic [7:0]        src_byte2;
  logic [7:0]        src_byte3;
  logic [IDX_W-1:0]  target_index;
  logic [WORD_W-1:0] target_word;

  modport source (
    output valid, action, glyph_x, glyph_y, src_byte0, src_byte1, src_byte2,
           src_byte3, target_index, target_word,
    input  ready
  );
  modport sink (
    input  valid, action, glyph_x, glyph_y, src_byte0, src_byte1, src_byte2,
           src_byte3, target_index, target_word,
    output ready
  );
endinterface

interface gbab_rsp_if import gbab_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              pixel_written;
  logic [IDX_W-1:0]  written_index;
  logic [WORD_W-1:0] read_word;

  modport source (
    output valid, pixel_written, written_index, read_word,
    input  ready
  );
  modport sink (
    input  valid, pixel_written, written_index, read_word,
    output ready
  );
endinterface

// File: design/glyph_blit_alpha_blend_unit.sv
// ----------------------------------------------------------------------------
// glyph_blit_alpha_blend_unit
// Clipped glyph blit, gray-blended or color-copied, into a 64K-word RGBA store.
// ----------------------------------------------------------------------------
// A request is taken only when the sequencer is idle; each item then walks
//   the place, index, read, multiply and finish steps against the target
//   store, and the next request waits until the finish step is done.
// A stalled result holds the finish step until the output register frees.
// Reset clears the sequencer, the result valid and the config registers
//   (size 256x256, all else 0); the target store is not cleared.
`timescale 1ns / 1ps
`include "glyph_blit_alpha_blend_unit_macros.svh"

module glyph_blit_alpha_blend_unit import gbab_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  gbab_req_if.sink          req,
  gbab_rsp_if.source        rsp
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [9:0] pos_x;
  logic signed [9:0] pos_y;
  logic signed [9:0] top_line;
  logic [8:0]        tgt_w;
  logic [8:0]        tgt_h;
  logic              mir_x;
  logic              mir_y;
  logic              color_src;
  logic              cfg_wr;
  logic [2:0]        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= '0;
      pos_y     <= '0;
      top_line  <= '0;
      tgt_w     <= 9'd256;
      tgt_h     <= 9'd256;
      mir_x     <= 1'b0;
      mir_y     <= 1'b0;
      color_src <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_POS_X:    pos_x     <= pwdata[9:0];
        REG_POS_Y:    pos_y     <= pwdata[9:0];
        REG_TOP_LINE: top_line  <= pwdata[9:0];
        REG_WIDTH:    tgt_w     <= pwdata[8:0];
        REG_HEIGHT:   tgt_h     <= pwdata[8:0];
        REG_MIRROR_X: mir_x     <= pwdata[0];
        REG_MIRROR_Y: mir_y     <= pwdata[0];
        REG_COLOR:    color_src <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_POS_X:    prdata = {22'd0, pos_x};
      REG_POS_Y:    prdata = {22'd0, pos_y};
      REG_TOP_LINE: prdata = {22'd0, top_line};
      REG_WIDTH:    prdata = {23'd0, tgt_w};
      REG_HEIGHT:   prdata = {23'd0, tgt_h};
      REG_MIRROR_X: prdata = {31'd0, mir_x};
      REG_MIRROR_Y: prdata = {31'd0, mir_y};
      REG_COLOR:    prdata = {31'd0, color_src};
      default:      prdata = '0;
    endcase
  end

  // Saturate the target size to what the store is laid out for
  logic [8:0] w_eff;
  logic [8:0] h_eff;
  assign w_eff = (tgt_w > W_LIMIT) ? W_LIMIT : tgt_w;
  assign h_eff = (tgt_h > H_LIMIT) ? H_LIMIT : tgt_h;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  gbab_state_t state;
  gbab_state_t state_next;
  logic        accept;
  logic        place_en;
  logic        index_en;
  logic        read_en;
  logic        mult_en;
  logic        advance;
  logic        done_fire;

  // The result register frees when it is empty or being drained this cycle
  assign advance = !rsp.valid || rsp.ready;
  assign accept  = req.valid && req.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req.valid) state_next = ST_PLACE;
      ST_PLACE: state_next = ST_INDEX;
      ST_INDEX: state_next = ST_READ;
      ST_READ:  state_next = ST_MULT;
      ST_MULT:  state_next = ST_DONE;
      ST_DONE:  if (advance) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    place_en  = 1'b0;
    index_en  = 1'b0;
    read_en   = 1'b0;
    mult_en   = 1'b0;
    done_fire = 1'b0;
    case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_PLACE: place_en  = 1'b1;
      ST_INDEX: index_en  = 1'b1;
      ST_READ:  read_en   = 1'b1;
      ST_MULT:  mult_en   = 1'b1;
      ST_DONE:  done_fire = advance;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Request capture
  // --------------------------------------------------------------------------
  gbab_action_t      act;
  logic [7:0]        gx;
  logic [7:0]        gy;
  logic [7:0]        b0;
  logic [7:0]        b1;
  logic [7:0]        b2;
  logic [7:0]        b3;
  logic [IDX_W-1:0]  t_idx;
  logic [WORD_W-1:0] t_word;

  always_ff @(posedge clk) begin
    if (accept) begin
      act    <= gbab_action_t'(req.action);
      gx     <= req.glyph_x;
      gy     <= req.glyph_y;
      b0     <= req.src_byte0;
      b1     <= req.src_byte1;
      b2     <= req.src_byte2;
      b3     <= req.src_byte3;
      t_idx  <= req.target_index;
      t_word <= req.target_word;
    end
  end

  // --------------------------------------------------------------------------
  // Place: offset, mirror and clip the destination coordinate
  // --------------------------------------------------------------------------
  logic signed [11:0] dx_raw;
  logic signed [11:0] dy_raw;
  logic signed [11:0] dx_m;
  logic signed [11:0] dy_m;
  logic signed [11:0] w_s;
  logic signed [11:0] h_s;
  logic               in_bounds;
  logic [7:0]         cov;
  logic [8:0]         dx_c;
  logic [8:0]         dy_c;
  logic               skip;

  assign w_s    = $signed({3'd0, w_eff});
  assign h_s    = $signed({3'd0, h_eff});
  assign dx_raw = 12'(pos_x) + $signed({4'd0, gx});
  assign dy_raw = 12'(pos_y) + $signed({4'd0, gy}) - 12'(top_line);
  assign dx_m   = mir_x ? (w_s - 12'sd1 - dx_raw) : dx_raw;
  assign dy_m   = mir_y ? (h_s - 12'sd1 - dy_raw) : dy_raw;
  assign in_bounds = !dx_m[11] && (dx_m < w_s) && !dy_m[11] && (dy_m < h_s);
  // Zero coverage (gray) or zero alpha (color) drops the pixel
  assign cov = color_src ? b3 : b0;

  always_ff @(posedge clk) begin
    if (place_en) begin
      dx_c <= dx_m[8:0];
      dy_c <= dy_m[8:0];
      skip <= (cov == 8'd0) || !in_bounds;
    end
  end

  // --------------------------------------------------------------------------
  // Index: row-major linear address, wrapped to the store size
  // --------------------------------------------------------------------------
  logic [17:0]      lin;
  logic [IDX_W-1:0] addr;

  assign lin = 18'(dy_c) * 18'(w_eff) + 18'(dx_c);

  always_ff @(posedge clk) begin
    if (index_en) begin
      addr <= (act == ACT_BLIT) ? lin[IDX_W-1:0] : t_idx;
    end
  end

  // --------------------------------------------------------------------------
  // Target store: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] store [1 << IDX_W];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;

  // Items run one at a time and the write lands before the next read, so
  // no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[addr] <= mem_wdata;
    end
    if (read_en) begin
      rd_data <= store[addr];
    end
  end

  // --------------------------------------------------------------------------
  // Multiply step computes (255 - b0) * old alpha
  // --------------------------------------------------------------------------
  logic [15:0] prod;

  always_ff @(posedge clk) begin
    if (mult_en) begin
      prod <= 16'(8'd255 - b0) * 16'(rd_data[31:24]);
    end
  end

  // --------------------------------------------------------------------------
  // Finish: exact floor divide by 255, build the result and write back
  // --------------------------------------------------------------------------
  logic [16:0]       q_sum;
  logic [7:0]        blend_alpha;
  logic              res_we;
  logic              res_pw;
  logic [IDX_W-1:0]  res_idx;
  logic [WORD_W-1:0] res_word;
  logic              gray_done;

  // floor(p / 255) == (p + 1 + (p >> 8)) >> 8 for every p up to 255 * 255
  assign q_sum       = 17'(prod) + 17'd1 + 17'(prod[15:8]);
  assign blend_alpha = b0 + q_sum[15:8];

  // A gray blend that lands on the target is about to finish
  assign gray_done = (state == ST_DONE) && (act == ACT_BLIT) && !color_src && !skip;

  always_comb begin
    res_we   = 1'b0;
    res_pw   = 1'b0;
    res_idx  = '0;
    res_word = '0;
    case (act)
      ACT_WRITE: begin
        res_we   = 1'b1;
        res_pw   = 1'b1;
        res_idx  = t_idx;
        res_word = t_word;
      end
      ACT_READ: begin
        res_word = rd_data;
      end
      ACT_BLIT: begin
        if (!skip) begin
          res_we   = 1'b1;
          res_pw   = 1'b1;
          res_idx  = addr;
          // Swizzle BGRA to RGBA; gray mode writes black with blended alpha
          res_word = color_src ? {b3, b0, b1, b2} : {blend_alpha, 24'd0};
        end
      end
      default: ;
    endcase
  end

  assign mem_we    = done_fire && res_we;
  assign mem_wdata = res_word;

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic              out_valid;
  logic              out_pw;
  logic [IDX_W-1:0]  out_idx;
  logic [WORD_W-1:0] out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_pw   <= res_pw;
      out_idx  <= res_idx;
      out_word <= res_word;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.pixel_written = out_pw;
  assign rsp.written_index = out_idx;
  assign rsp.read_word     = out_word;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `GBAB_ASSERT_NEXT(a_accept_starts_place, clk, rst, accept, state == ST_PLACE)
  `GBAB_ASSERT_NEXT(a_finish_shows_result, clk, rst, done_fire, rsp.valid)
  `GBAB_ASSERT_IMPL(a_blend_not_below_cov, clk, rst, gray_done, blend_alpha >= b0)
  `GBAB_ASSERT_IMPL(a_store_write_at_finish, clk, rst, mem_we, state == ST_DONE && advance)

endmodule
